### sv/pbs_pkg.sv
// Shared types and constants of the pixel brightness scaler.
package pbs_pkg;

    // Field widths.
    localparam int CHAN_W = 8;
    localparam int PCT_W = 11;
    localparam int DATA_W = 3 * CHAN_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_IDX_PERCENT = 1'b0;
    localparam logic REG_IDX_MODE = 1'b1;

    // Reset values of the registers.
    localparam logic signed [PCT_W-1:0] PERCENT_RESET = '0;
    localparam logic MODE_RESET = 1'b1;

    // Quotients by 100 are taken of values below 25600 only; larger ones saturate.
    localparam int QUOT_W = 15;
    localparam logic [QUOT_W-1:0] QUOT_LIMIT = 15'd25599;
    // Reciprocal of 100: ceil(2^21 / 100). Exact for every dividend below 43690.
    localparam logic [QUOT_W-1:0] RECIP_100 = 15'd20972;
    localparam int RECIP_SHIFT = 21;
    localparam int PROD_W = 2 * QUOT_W;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic signed [PCT_W-1:0] percent;
        logic                    rgb_mode;
    } cfg_t;

endpackage

### sv/pbs_cfg_regs.sv
// APB register file holding the brightness percentage and the pixel format.
module pbs_cfg_regs
    import pbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic                    wr_en;
    logic signed [PCT_W-1:0] percent_reg;
    logic signed [PCT_W-1:0] percent_next;
    logic                    mode_reg;
    logic                    mode_next;

    // The port never inserts wait states.
    assign pready = 1'b1;

    // A write completes in the access cycle.
    assign wr_en = psel && penable && pwrite && pready;

    // Next register values on a write transaction.
    always_comb
    begin
        percent_next = percent_reg;
        mode_next = mode_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_IDX_PERCENT: percent_next = pwdata[PCT_W-1:0];
                REG_IDX_MODE:    mode_next = pwdata[0];
                default:         ;
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            percent_reg <= PERCENT_RESET;
            mode_reg <= MODE_RESET;
        end
        else
        begin
            percent_reg <= percent_next;
            mode_reg <= mode_next;
        end
    end

    // Read back; the percentage is sign extended.
    always_comb
    begin
        case (paddr[2])
            REG_IDX_PERCENT: prdata = {{(APB_DATA_W-PCT_W){percent_reg[PCT_W-1]}}, percent_reg};
            REG_IDX_MODE:    prdata = {{(APB_DATA_W-1){1'b0}}, mode_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.percent = percent_reg;
    assign cfg.rgb_mode = mode_reg;

endmodule

### sv/pbs_pipe.sv
// Four-stage brightness datapath: extremes, product, numerator and clamp, quotient.
module pbs_pipe
    import pbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    // Stage valid bits and advance enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // Stage 1: channels, multiplicand and multiplier.
    logic [CHAN_W-1:0]       chan [3];
    logic [CHAN_W-1:0]       hi, lo;
    logic [CHAN_W:0]         s1_sum_next;
    logic signed [PCT_W:0]   s1_mul_next;
    logic [CHAN_W-1:0]       s1_chan_reg [3];
    logic [CHAN_W:0]         s1_sum_reg;
    logic signed [PCT_W:0]   s1_mul_reg;
    logic                    s1_mode_reg;

    // Stage 2: shared product.
    logic signed [PCT_W+CHAN_W+2:0] s2_prod_next;
    logic signed [PCT_W+CHAN_W+2:0] s2_prod_reg;
    logic [CHAN_W-1:0]              s2_chan_reg [3];
    logic                           s2_mode_reg;

    // Stage 3: clamped dividends for a division by 100.
    logic signed [PCT_W+CHAN_W+3:0] num [3];
    logic signed [PCT_W+CHAN_W+3:0] half [3];
    logic [QUOT_W-1:0]              s3_x_next [3];
    logic [QUOT_W-1:0]              s3_x_reg [3];
    logic                           s3_mode_reg;

    // Stage 4: quotients.
    logic [PROD_W-1:0] qprod [3];
    logic [CHAN_W-1:0] s4_res_next [3];
    logic [CHAN_W-1:0] s4_res_reg [3];
    logic              s4_mode_reg;

    // A stage advances when it is empty or the next one advances.
    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // Stage 1: maximum plus minimum in RGB mode, the gray value otherwise.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            chan[i] = in_data[i*CHAN_W +: CHAN_W];
        hi = chan[0];
        lo = chan[0];
        for (int i = 1; i < 3; i++)
        begin
            if (chan[i] > hi)
                hi = chan[i];
            if (chan[i] < lo)
                lo = chan[i];
        end
        if (cfg.rgb_mode)
        begin
            s1_sum_next = {1'b0, hi} + {1'b0, lo};
            s1_mul_next = {cfg.percent[PCT_W-1], cfg.percent};
        end
        else
        begin
            s1_sum_next = {1'b0, chan[0]};
            s1_mul_next = {cfg.percent[PCT_W-1], cfg.percent} + (PCT_W+1)'(100);
        end
    end

    // Stage 2: one signed product shared by all three channels.
    assign s2_prod_next = (PCT_W+CHAN_W+3)'($signed({1'b0, s1_sum_reg}))
                        * (PCT_W+CHAN_W+3)'(s1_mul_reg);

    // Stage 3: in RGB mode add 200 times the channel and halve; clamp to 0..25599.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (s2_mode_reg)
                num[i] = {s2_prod_reg[PCT_W+CHAN_W+2], s2_prod_reg}
                       + $signed({8'b0, s2_chan_reg[i], 7'b0})
                       + $signed({9'b0, s2_chan_reg[i], 6'b0})
                       + $signed({12'b0, s2_chan_reg[i], 3'b0});
            else
                num[i] = {s2_prod_reg[PCT_W+CHAN_W+2], s2_prod_reg};
            half[i] = s2_mode_reg ? (num[i] >>> 1) : num[i];
            if (!s2_mode_reg && i != 0)
                s3_x_next[i] = '0;
            else if (half[i] < 0)
                s3_x_next[i] = '0;
            else if (half[i] > $signed({{(PCT_W+CHAN_W+4-QUOT_W){1'b0}}, QUOT_LIMIT}))
                s3_x_next[i] = QUOT_LIMIT;
            else
                s3_x_next[i] = half[i][QUOT_W-1:0];
        end
    end

    // Stage 4: divide by 100 through the reciprocal.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qprod[i] = PROD_W'(s3_x_reg[i]) * PROD_W'(RECIP_100);
            s4_res_next[i] = qprod[i][RECIP_SHIFT +: CHAN_W];
        end
    end

    // Payload registers, loaded as their stage advances.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_chan_reg <= chan;
            s1_sum_reg <= s1_sum_next;
            s1_mul_reg <= s1_mul_next;
            s1_mode_reg <= cfg.rgb_mode;
        end
        if (en2)
        begin
            s2_prod_reg <= s2_prod_next;
            s2_chan_reg <= s1_chan_reg;
            s2_mode_reg <= s1_mode_reg;
        end
        if (en3)
        begin
            s3_x_reg <= s3_x_next;
            s3_mode_reg <= s2_mode_reg;
        end
        if (en4)
        begin
            s4_res_reg <= s4_res_next;
            s4_mode_reg <= s3_mode_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data = {s4_res_reg[2], s4_res_reg[1], s4_res_reg[0]};

    // Input is refused only when every stage holds an item.
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input refused while the pipeline has a bubble");

    // An accepted transaction occupies the first stage next cycle.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted transaction missing from the first stage");

    // A blocked first stage keeps its item.
    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en2) |=> (v1_reg && $stable(s1_sum_reg) && $stable(s1_mul_reg)))
        else $error("first stage changed while blocked");

    // Gray results carry zero in the unused channels.
    a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !s4_mode_reg) |-> (s4_res_reg[1] == '0 && s4_res_reg[2] == '0))
        else $error("gray result with nonzero unused channels");

endmodule

### sv/pixel_brightness_scale.sv
// Top level of the pixel brightness scaler: register file and pipelined datapath.
//
//  Channel  Direction  Signals                                Contents
//  s_axis   in         s_axis_tvalid/tready/tdata[23:0]       one pixel per transaction
//  m_axis   out        m_axis_tvalid/tready/tdata[23:0]       one brightened pixel
//  apb      in/out     psel penable pwrite paddr pwdata ...   brightness_percent, rgb_mode
//
// Each pixel passes through the pipeline stages extremes, shared multiply,
// numerator and clamp, reciprocal divide. One pixel enters per cycle while
// the output is taken. A stall holds each occupied stage in place, and empty
// stages still fill, so no transaction is lost or repeated. Reset is
// asynchronous, empties the pipeline and loads the register defaults.
module pixel_brightness_scale
    import pbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: chan_first[7:0], chan_second[15:8], chan_third[23:16].
    input  logic [DATA_W-1:0]     s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: res_first[7:0], res_second[15:8], res_third[23:16].
    output logic [DATA_W-1:0]     m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t cfg;

    // Configuration registers.
    pbs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Brightness pipeline.
    pbs_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
